### rtl/assert_macros.svh
// Assertion macros shared by the balls-into-bins statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/bib_pkg.sv
// Types, constants and helpers for the balls-into-bins statistics block.
package bib_pkg;

  localparam int MAX_BINS   = 131072;
  localparam int COUNT_BITS = 24;
  localparam int BIN_W      = 17;
  localparam int NB_W       = 18;
  localparam int LEVEL_W    = 2;
  localparam int BIN_AW     = $clog2(MAX_BINS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX      = '1;
  localparam logic [NB_W-1:0]       NUM_BINS_RESET = NB_W'(1000);
  localparam logic [LEVEL_W-1:0]    LEVEL_FULL     = LEVEL_W'(2);

  localparam logic OP_THROW     = 1'b0;
  localparam logic OP_NEW_TRIAL = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_BIN    = 2'd1,
    ST_AFTER_DONE = 2'd2,
    ST_SATURATED  = 2'd3
  } status_t;

  typedef enum logic {
    SW_IDLE,
    SW_RUN
  } sweep_state_t;

  typedef struct packed {
    logic             op;
    logic [BIN_W-1:0] bin_index;
  } in_beat_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] balls_thrown;
    logic [COUNT_BITS-1:0] collision_time;
    logic [NB_W-1:0]       empty_after_n;
    logic [COUNT_BITS-1:0] all_filled_time;
    logic [COUNT_BITS-1:0] all_two_time;
    logic [COUNT_BITS-1:0] two_minus_filled;
    logic                  finished;
    status_t               status;
  } out_beat_t;

  typedef struct packed {
    logic              active;
    logic [BIN_AW-1:0] addr;
  } sweep_t;

  typedef struct packed {
    logic               wr_en;
    logic [LEVEL_W-1:0] level;
  } level_upd_t;

  function automatic logic [NB_W-1:0] eff_bins(input logic [NB_W-1:0] nb);
    logic [NB_W-1:0] r;
    r = nb;
    if (nb == '0) begin
      r = NB_W'(1);
    end else if (nb > NB_W'(MAX_BINS)) begin
      r = NB_W'(MAX_BINS);
    end
    return r;
  endfunction

endpackage

### rtl/bib_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bib_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/bib_sweep.sv
// Clearing sequencer that zeroes the bin levels of the bins in use.
`include "assert_macros.svh"
module bib_sweep (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [bib_pkg::NB_W-1:0] eff,
  output bib_pkg::sweep_t        sw
);
  import bib_pkg::*;

  sweep_state_t      state_r, state_nxt;
  logic [BIN_AW-1:0] addr_r, addr_nxt;
  logic              last;

  assign last = (NB_W'(addr_r) == (eff - NB_W'(1)));

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    if (start) begin
      state_nxt = SW_RUN;
      addr_nxt  = '0;
    end else begin
      case (state_r)
        SW_RUN: begin
          if (last) begin
            state_nxt = SW_IDLE;
          end else begin
            addr_nxt = addr_r + BIN_AW'(1);
          end
        end
        SW_IDLE: begin
          state_nxt = SW_IDLE;
        end
        default: begin
          state_nxt = SW_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    sw.addr = addr_r;
    case (state_r)
      SW_RUN:  sw.active = 1'b1;
      SW_IDLE: sw.active = 1'b0;
      default: sw.active = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SW_RUN;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  `ASSERT_ALWAYS(a_sweep_in_range, !sw.active || (NB_W'(addr_r) < eff), "sweep beyond bins in use")

endmodule

### rtl/bib_stats.sv
// Trial statistics registers and the per-beat update of counts and times.
`include "assert_macros.svh"
module bib_stats (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       trial_clear,
  input  logic [bib_pkg::NB_W-1:0]    num_bins,
  input  logic [bib_pkg::NB_W-1:0]    eff,
  input  logic                       step,
  input  bib_pkg::in_beat_t          beat,
  input  logic [bib_pkg::LEVEL_W-1:0] level,
  output bib_pkg::level_upd_t        upd,
  output bib_pkg::out_beat_t         res
);
  import bib_pkg::*;

  logic [COUNT_BITS-1:0] ball_r, ball_nxt;
  logic [NB_W-1:0]       empty_left_r, empty_left_nxt;
  logic [NB_W-1:0]       below_two_left_r, below_two_left_nxt;
  logic [COUNT_BITS-1:0] first_hit_r, first_hit_nxt;
  logic [COUNT_BITS-1:0] filled_time_r, filled_time_nxt;
  logic [COUNT_BITS-1:0] doubled_time_r, doubled_time_nxt;
  logic [NB_W-1:0]       snapshot_r, snapshot_nxt;
  logic                  done_r, done_nxt;
  status_t               status;
  logic                  new_trial;

  assign new_trial = trial_clear || (step && (beat.op == OP_NEW_TRIAL));

  always_comb begin
    ball_nxt           = ball_r;
    empty_left_nxt     = empty_left_r;
    below_two_left_nxt = below_two_left_r;
    first_hit_nxt      = first_hit_r;
    filled_time_nxt    = filled_time_r;
    doubled_time_nxt   = doubled_time_r;
    snapshot_nxt       = snapshot_r;
    done_nxt           = done_r;
    status             = ST_OK;
    upd.wr_en          = 1'b0;
    upd.level          = level + LEVEL_W'(1);
    if (new_trial) begin
      ball_nxt           = '0;
      empty_left_nxt     = eff;
      below_two_left_nxt = eff;
      first_hit_nxt      = '0;
      filled_time_nxt    = '0;
      doubled_time_nxt   = '0;
      snapshot_nxt       = '0;
      done_nxt           = 1'b0;
    end else if (step) begin
      if (done_r) begin
        status = ST_AFTER_DONE;
      end else if (NB_W'(beat.bin_index) >= eff) begin
        status = ST_BAD_BIN;
      end else if (ball_r >= (COUNT_MAX - COUNT_BITS'(1))) begin
        ball_nxt = COUNT_MAX;
        done_nxt = 1'b1;
        status   = ST_SATURATED;
      end else begin
        ball_nxt = ball_r + COUNT_BITS'(1);
        if ((level != '0) && (first_hit_r == '0)) begin
          first_hit_nxt = ball_nxt;
        end
        if ((level == '0) && (empty_left_r != '0)) begin
          empty_left_nxt = empty_left_r - NB_W'(1);
        end
        if ((level == LEVEL_W'(1)) && (below_two_left_r != '0)) begin
          below_two_left_nxt = below_two_left_r - NB_W'(1);
        end
        upd.wr_en = (level < LEVEL_FULL);
        if ((filled_time_r == '0) && (empty_left_nxt == '0)) begin
          filled_time_nxt = ball_nxt;
        end
        if (below_two_left_nxt == '0) begin
          doubled_time_nxt = ball_nxt;
          done_nxt         = 1'b1;
        end
        if (ball_nxt == COUNT_BITS'(num_bins)) begin
          snapshot_nxt = empty_left_nxt;
        end
      end
    end
  end

  always_comb begin
    res.balls_thrown     = ball_nxt;
    res.collision_time   = first_hit_nxt;
    res.empty_after_n    = snapshot_nxt;
    res.all_filled_time  = filled_time_nxt;
    res.all_two_time     = doubled_time_nxt;
    res.two_minus_filled = (doubled_time_nxt != '0) ? (doubled_time_nxt - filled_time_nxt) : '0;
    res.finished         = done_nxt;
    res.status           = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ball_r           <= '0;
      empty_left_r     <= eff_bins(NUM_BINS_RESET);
      below_two_left_r <= eff_bins(NUM_BINS_RESET);
      first_hit_r      <= '0;
      filled_time_r    <= '0;
      doubled_time_r   <= '0;
      snapshot_r       <= '0;
      done_r           <= 1'b0;
    end else begin
      ball_r           <= ball_nxt;
      empty_left_r     <= empty_left_nxt;
      below_two_left_r <= below_two_left_nxt;
      first_hit_r      <= first_hit_nxt;
      filled_time_r    <= filled_time_nxt;
      doubled_time_r   <= doubled_time_nxt;
      snapshot_r       <= snapshot_nxt;
      done_r           <= done_nxt;
    end
  end

  `ASSERT_ALWAYS(a_empty_le_below, empty_left_r <= below_two_left_r, "empty count above below-two count")
  `ASSERT_ALWAYS(a_doubled_done, (doubled_time_r == '0) || done_r, "all-two time set without finish")

endmodule

### rtl/balls_into_bins_statistics.sv
// Balls-into-bins statistics: one trial, per-bin fill levels held in a RAM, one result per beat.
// On a throw, the accepting edge starts the read of the bin's level from the level RAM, and
// the next edge writes the new level back and loads the result register; the next beat is
// taken only after that write-back and while the result register is free or being drained.
// Reset, a new-trial beat or a write to num_bins starts a clearing pass over the bins in use,
// one bin a cycle (the effective bin count is 1000 after reset), during which in_ready is
// low; the new-trial result is delivered at the start of that pass.
`include "assert_macros.svh"
module balls_into_bins_statistics (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [bib_pkg::NB_W-1:0] cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  bib_pkg::in_beat_t       in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output bib_pkg::out_beat_t      out_data
);
  import bib_pkg::*;

  logic [NB_W-1:0]    num_bins_r, num_bins_nxt;
  logic [NB_W-1:0]    eff;
  logic [NB_W-1:0]    trial_eff;
  logic               s1_valid_r, s1_valid_nxt;
  in_beat_t           s1_beat_r;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r;
  logic               in_fire;
  logic               sweep_start;
  sweep_t             sweep;
  level_upd_t         upd;
  out_beat_t          res;
  logic [LEVEL_W-1:0] level;
  logic               ram_we;
  logic [BIN_AW-1:0]  ram_waddr;
  logic [LEVEL_W-1:0] ram_wdata;

  assign eff         = eff_bins(num_bins_r);
  // a num_bins write restarts the trial with the new bin count
  assign trial_eff   = eff_bins(num_bins_nxt);
  assign in_ready    = !s1_valid_r && !sweep.active && (!out_valid_r || out_ready);
  assign in_fire     = in_valid && in_ready;
  assign sweep_start = cfg_wr_en || (s1_valid_r && (s1_beat_r.op == OP_NEW_TRIAL));

  assign num_bins_nxt  = cfg_wr_en ? cfg_wr_data : num_bins_r;
  assign s1_valid_nxt  = in_fire;
  assign out_valid_nxt = s1_valid_r || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r  <= NUM_BINS_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      num_bins_r  <= num_bins_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_beat_r <= in_data;
    end
    if (s1_valid_r) begin
      out_data_r <= res;
    end
  end

  assign ram_we    = sweep.active || (s1_valid_r && upd.wr_en);
  assign ram_waddr = sweep.active ? sweep.addr : BIN_AW'(s1_beat_r.bin_index);
  assign ram_wdata = sweep.active ? '0 : upd.level;

  bib_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (MAX_BINS)
  ) u_level_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (BIN_AW'(in_data.bin_index)),
    .rdata (level)
  );

  bib_sweep u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sweep_start),
    .eff   (eff),
    .sw    (sweep)
  );

  bib_stats u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .trial_clear (cfg_wr_en),
    .num_bins    (num_bins_r),
    .eff         (trial_eff),
    .step        (s1_valid_r),
    .beat        (s1_beat_r),
    .level       (level),
    .upd         (upd),
    .res         (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_one_in_flight, s1_valid_r, !s1_valid_r, "second beat entered the level read")
  `ASSERT_ALWAYS(a_out_free, !(s1_valid_r && out_valid_r), "result register busy at write-back")
  `ASSERT_NEXT(a_result_follows, s1_valid_r, out_valid_r, "write-back without a result beat")

endmodule

### tb/balls_into_bins_statistics_tb.sv
// Self-checking testbench for balls_into_bins_statistics: directed table, then random trials.
module balls_into_bins_statistics_tb;
  import bib_pkg::*;

  localparam int QUIET_LIMIT = 400000;

  typedef struct {
    bit              set_nb;
    logic [NB_W-1:0] nb;
    in_beat_t        beat;
    bit              typed;
    out_beat_t       want;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [NB_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;

  // predictor state
  logic [LEVEL_W-1:0]    fill_lvl [MAX_BINS];
  logic [NB_W-1:0]       nb_reg;
  logic [COUNT_BITS-1:0] ball_cnt;
  logic [NB_W-1:0]       empty_cnt;
  logic [NB_W-1:0]       below_two_cnt;
  logic [COUNT_BITS-1:0] first_hit;
  logic [COUNT_BITS-1:0] filled_at;
  logic [COUNT_BITS-1:0] doubled_at;
  logic [NB_W-1:0]       snap;
  logic                  trial_done;

  out_beat_t pending_stats [$];
  dir_row_t  dir_rows [$];
  out_beat_t oldest_stat;
  int        mismatches = 0;
  int        stats_seen = 0;
  int        quiet_cycles = 0;
  int        burst_left = 0;

  balls_into_bins_statistics dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [NB_W-1:0] live_bins(input logic [NB_W-1:0] nb);
    if (nb == '0) begin
      return NB_W'(1);
    end
    return (nb > NB_W'(MAX_BINS)) ? NB_W'(MAX_BINS) : nb;
  endfunction

  function automatic void restart_trial();
    logic [NB_W-1:0] live;
    live = live_bins(nb_reg);
    for (int i = 0; i < int'(live); i++) begin
      fill_lvl[i] = '0;
    end
    ball_cnt      = '0;
    empty_cnt     = live;
    below_two_cnt = live;
    first_hit     = '0;
    filled_at     = '0;
    doubled_at    = '0;
    snap          = '0;
    trial_done    = 1'b0;
  endfunction

  function automatic out_beat_t occupancy_after(input in_beat_t b);
    out_beat_t r;
    logic [LEVEL_W-1:0] lvl;
    status_t st;
    st = ST_OK;
    if (b.op == OP_NEW_TRIAL) begin
      restart_trial();
    end else if (trial_done) begin
      st = ST_AFTER_DONE;
    end else if (NB_W'(b.bin_index) >= live_bins(nb_reg)) begin
      st = ST_BAD_BIN;
    end else if (ball_cnt >= COUNT_MAX - 1'b1) begin
      ball_cnt   = COUNT_MAX;
      trial_done = 1'b1;
      st         = ST_SATURATED;
    end else begin
      lvl = fill_lvl[b.bin_index];
      ball_cnt++;
      if (lvl != '0 && first_hit == '0) begin
        first_hit = ball_cnt;
      end
      if (lvl == LEVEL_W'(0) && empty_cnt != '0) begin
        empty_cnt--;
      end
      if (lvl == LEVEL_W'(1) && below_two_cnt != '0) begin
        below_two_cnt--;
      end
      if (lvl < LEVEL_FULL) begin
        fill_lvl[b.bin_index] = lvl + 1'b1;
      end
      if (filled_at == '0 && empty_cnt == '0) begin
        filled_at = ball_cnt;
      end
      if (below_two_cnt == '0) begin
        doubled_at = ball_cnt;
        trial_done = 1'b1;
      end
      if (ball_cnt == COUNT_BITS'(nb_reg)) begin
        snap = empty_cnt;
      end
    end
    r.balls_thrown     = ball_cnt;
    r.collision_time   = first_hit;
    r.empty_after_n    = snap;
    r.all_filled_time  = filled_at;
    r.all_two_time     = doubled_at;
    r.two_minus_filled = (doubled_at != '0) ? doubled_at - filled_at : '0;
    r.finished         = trial_done;
    r.status           = st;
    return r;
  endfunction

  function automatic out_beat_t stat(input int unsigned balls, input int unsigned coll,
                                     input int unsigned empt, input int unsigned filled,
                                     input int unsigned two, input int unsigned gap,
                                     input logic fin, input status_t st);
    out_beat_t r;
    r.balls_thrown     = COUNT_BITS'(balls);
    r.collision_time   = COUNT_BITS'(coll);
    r.empty_after_n    = NB_W'(empt);
    r.all_filled_time  = COUNT_BITS'(filled);
    r.all_two_time     = COUNT_BITS'(two);
    r.two_minus_filled = COUNT_BITS'(gap);
    r.finished         = fin;
    r.status           = st;
    return r;
  endfunction

  function automatic void add_row(input bit set_nb, input int unsigned nb, input logic op,
                                  input int unsigned bin, input bit typed,
                                  input out_beat_t want);
    dir_row_t row;
    row.set_nb         = set_nb;
    row.nb             = NB_W'(nb);
    row.beat.op        = op;
    row.beat.bin_index = BIN_W'(bin);
    row.typed          = typed;
    row.want           = want;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    logic [NB_W-1:0] live;
    int r;
    live = live_bins(nb_reg);
    r = $urandom_range(0, 99);
    b.op = OP_THROW;
    b.bin_index = BIN_W'($urandom_range(0, (1 << BIN_W) - 1));
    if (trial_done) begin
      if (r < 75) begin
        b.op = OP_NEW_TRIAL;
      end else if (r < 90) begin
        b.bin_index = BIN_W'($urandom_range(0, int'(live) - 1));
      end
    end else if (r < 3 && live <= NB_W'(4096)) begin
      b.op = OP_NEW_TRIAL;
    end else if (r >= 10) begin
      b.bin_index = BIN_W'($urandom_range(0, int'(live) - 1));
    end
    return b;
  endfunction

  function automatic void phase_plan(input int p, output logic [NB_W-1:0] nb, output int items);
    case (p)
      0:       begin nb = NB_W'(5);      items = 200; end
      1:       begin nb = NB_W'(1);      items = 80;  end
      2:       begin nb = NB_W'(2);      items = 100; end
      3:       begin nb = NB_W'(40);     items = 300; end
      4:       begin nb = NB_W'(131072); items = 60;  end
      5:       begin nb = '1;            items = 60;  end
      6:       begin nb = NB_W'(12);     items = 200; end
      default: begin nb = NB_W'(1000);   items = 150; end
    endcase
  endfunction

  task automatic cmp_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 40) begin
        $display("%0t mismatch %s: expected %0d, got %0d", $time, name, e, a);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  // offer one beat, predict at acceptance, then maybe end the burst
  task automatic offer(input in_beat_t b, input bit typed, input out_beat_t want);
    out_beat_t predicted;
    int gap;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = occupancy_after(b);
    pending_stats.insert(pending_stats.size(), typed ? want : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // only once idle: results drained and any clearing pass over
  task automatic write_num_bins(input logic [NB_W-1:0] nb);
    in_valid <= 1'b0;
    wait_drained();
    repeat (2) @(posedge clk);
    while (!in_ready) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= nb;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    nb_reg = nb;
    restart_trial();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      stats_seen++;
      if (pending_stats.size() == 0) begin
        mismatches++;
        $display("%0t unexpected beat: expected none, got balls %0d status %0d",
                 $time, out_data.balls_thrown, out_data.status);
      end else begin
        oldest_stat = pending_stats.pop_front();
        cmp_field("balls_thrown", 32'(oldest_stat.balls_thrown), 32'(out_data.balls_thrown));
        cmp_field("collision_time", 32'(oldest_stat.collision_time),
                  32'(out_data.collision_time));
        cmp_field("empty_after_n", 32'(oldest_stat.empty_after_n), 32'(out_data.empty_after_n));
        cmp_field("all_filled_time", 32'(oldest_stat.all_filled_time),
                  32'(out_data.all_filled_time));
        cmp_field("all_two_time", 32'(oldest_stat.all_two_time), 32'(out_data.all_two_time));
        cmp_field("two_minus_filled", 32'(oldest_stat.two_minus_filled),
                  32'(out_data.two_minus_filled));
        cmp_field("finished", 32'(oldest_stat.finished), 32'(out_data.finished));
        cmp_field("status", 32'(oldest_stat.status), 32'(out_data.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t no beat for %0d cycles", $time, QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  // receiver: changing stall pattern, one long hold-off to back the block up
  initial begin : receiver
    int mode;
    int tick;
    bit held;
    mode = 0;
    tick = 0;
    held = 1'b0;
    forever begin
      if (!held && stats_seen >= 500) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        if (tick % 50 == 0) begin
          mode = $urandom_range(0, 3);
        end
        tick++;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [NB_W-1:0] nb;
    int items;
    nb_reg = NUM_BINS_RESET;
    restart_trial();

    // after reset, 1000 bins
    add_row(0, 0, OP_THROW, 0, 1, stat(1, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(0, 0, OP_THROW, 999, 1, stat(2, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(0, 0, OP_THROW, 1000, 1, stat(2, 0, 0, 0, 0, 0, 0, ST_BAD_BIN));
    add_row(0, 0, OP_THROW, 17'h1FFFF, 1, stat(2, 0, 0, 0, 0, 0, 0, ST_BAD_BIN));
    add_row(0, 0, OP_THROW, 0, 1, stat(3, 3, 0, 0, 0, 0, 0, ST_OK));
    add_row(0, 0, OP_THROW, 0, 1, stat(4, 3, 0, 0, 0, 0, 0, ST_OK));
    add_row(0, 0, OP_NEW_TRIAL, 17'h1FFFF, 1, stat(0, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(0, 0, OP_THROW, 5, 0, '0);
    // two bins: fill, double up, then throws after finish
    add_row(1, 2, OP_THROW, 0, 1, stat(1, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(0, 0, OP_THROW, 1, 1, stat(2, 0, 0, 2, 0, 0, 0, ST_OK));
    add_row(0, 0, OP_THROW, 0, 1, stat(3, 3, 0, 2, 0, 0, 0, ST_OK));
    add_row(0, 0, OP_THROW, 1, 1, stat(4, 3, 0, 2, 4, 2, 1, ST_OK));
    add_row(0, 0, OP_THROW, 0, 1, stat(4, 3, 0, 2, 4, 2, 1, ST_AFTER_DONE));
    add_row(0, 0, OP_THROW, 5, 1, stat(4, 3, 0, 2, 4, 2, 1, ST_AFTER_DONE));
    add_row(0, 0, OP_NEW_TRIAL, 0, 1, stat(0, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(0, 0, OP_THROW, 1, 0, '0);
    // zero bins behaves as one
    add_row(1, 0, OP_THROW, 1, 1, stat(0, 0, 0, 0, 0, 0, 0, ST_BAD_BIN));
    add_row(0, 0, OP_THROW, 0, 1, stat(1, 0, 0, 1, 0, 0, 0, ST_OK));
    add_row(0, 0, OP_THROW, 0, 1, stat(2, 2, 0, 1, 2, 1, 1, ST_OK));
    // three bins: snapshot with one bin still empty
    add_row(1, 3, OP_THROW, 0, 0, '0);
    add_row(0, 0, OP_THROW, 0, 0, '0);
    add_row(0, 0, OP_THROW, 1, 0, '0);
    add_row(0, 0, OP_THROW, 2, 0, '0);
    add_row(0, 0, OP_NEW_TRIAL, 0, 0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_nb) begin
        write_num_bins(dir_rows[i].nb);
      end
      offer(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < 8; p++) begin
      phase_plan(p, nb, items);
      write_num_bins(nb);
      for (int i = 0; i < items; i++) begin
        if (p == 6 && i == 100) begin
          in_valid <= 1'b0;
          wait_drained();
          @(posedge clk);
        end
        offer(random_beat(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### balls_into_bins_statistics.f
+incdir+rtl
rtl/bib_pkg.sv
rtl/bib_ram.sv
rtl/bib_sweep.sv
rtl/bib_stats.sv
rtl/balls_into_bins_statistics.sv
tb/balls_into_bins_statistics_tb.sv
